[design/tvls_pkg.sv]
// shared widths, defaults and the multiplier request type for the visible length sweep
`default_nettype none
package tvls_pkg;
    localparam int COORD_W       = 24;  // port width of one coordinate
    localparam int LEN_W         = 25;  // edge length, Q17.8
    localparam int TOT_W         = 36;  // running total, Q28.8
    localparam int MUL_A_W       = 34;  // signed multiplicand
    localparam int MUL_B_W       = 26;  // signed multiplier, walked one bit a cycle
    localparam int PROD_W        = 59;  // signed product
    localparam int DEF_COORD_BITS = 24;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W-1:0]   a;
        logic signed [MUL_B_W-1:0]   b;
    } t_mul_req;
endpackage
`default_nettype wire

[design/tvls_mul.sv]
// bit-serial signed multiplier, one multiplier bit per cycle
`default_nettype none
module tvls_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire tvls_pkg::t_mul_req                    i_req,
    output logic                                       o_done,
    output logic signed [tvls_pkg::PROD_W-1:0]         o_p
);
    import tvls_pkg::*;

    localparam int MAG_W = PROD_W - 1;
    localparam int BM_W  = MUL_B_W - 1;

    logic                  r_busy;
    logic [4:0]            r_cnt;
    logic [MAG_W-1:0]      r_am;
    logic [BM_W-1:0]       r_bm;
    logic [MAG_W-1:0]      r_acc;
    logic                  r_neg;
    logic                  r_done;
    logic signed [PROD_W-1:0] r_p;

    logic [MUL_A_W-1:0]    a_abs;
    logic [MUL_B_W-1:0]    b_abs;
    logic [MAG_W-1:0]      n_acc;

    always_comb begin
        a_abs = i_req.a[MUL_A_W-1] ? MUL_A_W'(-i_req.a) : MUL_A_W'(i_req.a);
        b_abs = i_req.b[MUL_B_W-1] ? MUL_B_W'(-i_req.b) : MUL_B_W'(i_req.b);
        n_acc = r_bm[0] ? r_acc + r_am : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_am   <= MAG_W'(a_abs[MUL_A_W-2:0]);
                    r_bm   <= b_abs[BM_W-1:0];
                    r_acc  <= '0;
                    r_neg  <= i_req.a[MUL_A_W-1] ^ i_req.b[MUL_B_W-1];
                end
            end else begin
                r_acc <= n_acc;
                r_am  <= {r_am[MAG_W-2:0], 1'b0};
                r_bm  <= {1'b0, r_bm[BM_W-1:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(BM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_p    <= r_neg ? -$signed({1'b0, n_acc}) : $signed({1'b0, n_acc});
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

[design/terrain_visible_length_sweep_core.sv]
// terrain visible length sweep: sequencer, square root, divider and output register
//
//  channel   | dir | handshake          | content
//  s (vertex)| in  | i_s_tvalid/o_s_tready | tdata x,y ; tlast last_vertex
//  m (result)| out | o_m_tvalid/i_m_tready | tdata length,total ; tuser edge_present ; tlast done
//  cfg       | in  | i_cfg_wr_en        | observer_height
//
// one vertex passes through eight serial products on the shared multiplier, 25 square root
// steps, up to 20 normalising shifts, one more product and 25 divider steps. the next vertex
// is taken once the sequencer is back at rest.
// synchronous active-low reset clears the sequencer, previous vertex, blocker, total, output valid and observer height.
// a result waiting on a stalled output is held; the next vertex may be accepted meanwhile.
`default_nettype none
module terrain_visible_length_sweep_core #(
    parameter int COORD_BITS = tvls_pkg::DEF_COORD_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [23:0] i_cfg_wr_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // vertex_x [23:0], vertex_y [47:24]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // edge_visible_length [24:0], total_visible [60:25]
    output logic             o_m_tuser,   // edge_present
    output logic             o_m_tlast
);
    import tvls_pkg::*;

    localparam int CW = (COORD_BITS > COORD_W) ? COORD_W : COORD_BITS;
    localparam logic [COORD_W-1:0] CMASK = (COORD_W'(1) << CW) - COORD_W'(1);
    localparam int WW = 52;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MWAIT, S_SQRT, S_PREP, S_SHIFT, S_DIV, S_DONE
    } t_state;

    t_state r_state;
    logic [3:0] r_step;
    logic [4:0] r_cnt;

    logic [COORD_W-1:0] r_h, r_x, r_y, r_px, r_py, r_bx, r_by;
    logic r_last, r_have_prev, r_have_block;
    logic [TOT_W-1:0] r_total;

    logic signed [PROD_W-1:0] r_t;
    logic signed [WW-1:0] r_cross, r_c1, r_c2, r_d;
    logic [WW-1:0] r_ud, r_uq;
    logic [49:0] r_sv;
    logic [27:0] r_srem;
    logic [LEN_W-1:0] r_len;
    logic [31:0] r_rem;
    logic [LEN_W-1:0] r_q;

    logic r_out_valid, r_out_present, r_out_last;
    logic [LEN_W-1:0] r_out_len;
    logic [TOT_W-1:0] r_out_total;

    t_mul_req mul_req;
    logic mul_done;
    logic signed [PROD_W-1:0] mul_p;

    tvls_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    logic signed [LEN_W-1:0] ymh, pymh, a_blk, dx, dy;
    logic signed [WW-1:0] d_c, n_c, n_cl;
    logic [27:0] sq_rem, sq_trial;
    logic sq_ge;
    logic [32:0] dv_rem;
    logic dv_ge;
    logic [LEN_W-1:0] vis;
    logic [TOT_W:0] sum;
    logic new_block;
    logic out_load;

    always_comb begin
        ymh   = $signed({1'b0, r_y})  - $signed({1'b0, r_h});
        pymh  = $signed({1'b0, r_py}) - $signed({1'b0, r_h});
        a_blk = $signed({1'b0, r_by}) - $signed({1'b0, r_h});
        dx    = $signed({1'b0, r_x})  - $signed({1'b0, r_px});
        dy    = $signed({1'b0, r_y})  - $signed({1'b0, r_py});

        mul_req.start = (r_state == S_MUL);
        case (r_step)
            4'd0: begin mul_req.a = MUL_A_W'(ymh);   mul_req.b = {2'b0, r_px}; end
            4'd1: begin mul_req.a = MUL_A_W'(pymh);  mul_req.b = {2'b0, r_x};  end
            4'd2: begin mul_req.a = MUL_A_W'(ymh);   mul_req.b = {2'b0, r_bx}; end
            4'd3: begin mul_req.a = MUL_A_W'(a_blk); mul_req.b = {2'b0, r_x};  end
            4'd4: begin mul_req.a = MUL_A_W'(pymh);  mul_req.b = {2'b0, r_bx}; end
            4'd5: begin mul_req.a = MUL_A_W'(a_blk); mul_req.b = {2'b0, r_px}; end
            4'd6: begin mul_req.a = MUL_A_W'(dx);    mul_req.b = MUL_B_W'(dx); end
            4'd7: begin mul_req.a = MUL_A_W'(dy);    mul_req.b = MUL_B_W'(dy); end
            default: begin
                mul_req.a = $signed({2'b0, r_uq[31:0]});
                mul_req.b = $signed({1'b0, r_len});
            end
        endcase

        // d and n fall out of the two blocker cross products
        d_c  = r_c1 - r_c2;
        n_c  = -r_c2;
        n_cl = (n_c < 0) ? '0 : ((n_c > d_c) ? d_c : n_c);

        sq_rem   = {r_srem[25:0], r_sv[49:48]};
        sq_trial = {1'b0, r_len, 2'b01};
        sq_ge    = (sq_rem >= sq_trial);

        dv_rem = {r_rem, r_q[LEN_W-1]};
        dv_ge  = (dv_rem >= {1'b0, r_ud[31:0]});

        vis = '0;
        if (r_have_prev && (r_x > r_px)) begin
            if (r_px == '0 && !r_have_block) begin
                vis = r_len;
            end else if (r_cross > 0) begin
                if (!r_have_block) begin
                    vis = r_len;
                end else if (r_c1 < 0) begin
                    vis = '0;
                end else if (r_c2 >= 0) begin
                    vis = r_len;
                end else if (r_d <= 0) begin
                    vis = '0;
                end else begin
                    vis = r_q;
                end
            end
        end
        sum = {1'b0, r_total} + (TOT_W+1)'(vis);
        new_block = (r_x != '0) && (!r_have_block || r_c1 > 0);
        out_load  = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_cnt        <= '0;
            r_h          <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_bx         <= '0;
            r_by         <= '0;
            r_have_prev  <= 1'b0;
            r_have_block <= 1'b0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_h <= i_cfg_wr_data & CMASK;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_x     <= i_s_tdata[23:0] & CMASK;
                        r_y     <= i_s_tdata[47:24] & CMASK;
                        r_last  <= i_s_tlast;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (mul_done) begin
                        case (r_step)
                            4'd1: r_cross <= WW'(r_t - mul_p);
                            4'd3: r_c1    <= WW'(r_t - mul_p);
                            4'd5: r_c2    <= WW'(r_t - mul_p);
                            4'd7: r_sv    <= {1'b0, 49'(r_t + mul_p)};
                            4'd8: begin
                                r_rem <= mul_p[56:25];
                                r_q   <= mul_p[24:0];
                            end
                            default: r_t <= mul_p;
                        endcase
                        r_cnt <= '0;
                        if (r_step == 4'd7) begin
                            r_srem  <= '0;
                            r_len   <= '0;
                            r_state <= S_SQRT;
                        end else if (r_step == 4'd8) begin
                            r_state <= S_DIV;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_SQRT: begin
                    // two radicand bits per step, one root bit out
                    r_sv   <= {r_sv[47:0], 2'b00};
                    r_srem <= sq_ge ? sq_rem - sq_trial : sq_rem;
                    r_len  <= {r_len[LEN_W-2:0], sq_ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(LEN_W - 1)) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_d     <= d_c;
                    r_ud    <= d_c;
                    r_uq    <= d_c - n_cl;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_ud[WW-1:32] == '0) begin
                        r_step  <= 4'd8;
                        r_state <= S_MUL;
                    end else begin
                        r_ud <= {1'b0, r_ud[WW-1:1]};
                        r_uq <= {1'b0, r_uq[WW-1:1]};
                    end
                end
                S_DIV: begin
                    r_rem <= dv_ge ? 32'(dv_rem - {1'b0, r_ud[31:0]}) : dv_rem[31:0];
                    r_q   <= {r_q[LEN_W-2:0], dv_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(LEN_W - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_present <= r_have_prev;
                        r_out_len     <= vis;
                        // total shown with the beat is the one after this edge, before any clear
                        r_out_total   <= sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
                        r_out_last    <= r_last;
                        r_state       <= S_IDLE;
                        if (r_last) begin
                            r_px         <= '0;
                            r_py         <= '0;
                            r_bx         <= '0;
                            r_by         <= '0;
                            r_have_prev  <= 1'b0;
                            r_have_block <= 1'b0;
                            r_total      <= '0;
                        end else begin
                            r_px        <= r_x;
                            r_py        <= r_y;
                            r_have_prev <= 1'b1;
                            r_total     <= sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
                            if (new_block) begin
                                r_bx         <= r_x;
                                r_by         <= r_y;
                                r_have_block <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_total, r_out_len};
    assign o_m_tuser  = r_out_present;
    assign o_m_tlast  = r_out_last;
endmodule
`default_nettype wire

[tb/sv/tb_terrain_visible_length_sweep_core.sv]
// testbench for the terrain visible length sweep: directed table, random polylines, scoreboard
`timescale 1ns / 1ps
module tb_terrain_visible_length_sweep_core;
    import tvls_pkg::*;

    typedef struct packed {
        logic                present;
        logic [LEN_W-1:0]    vis_len;
        logic [TOT_W-1:0]    total;
        logic                done;
    } t_edge_res;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               known;
        t_edge_res          res;
    } t_row;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [23:0]       i_cfg_wr_data = '0;
    logic              i_s_tvalid = 1'b0;
    logic [47:0]       i_s_tdata = '0;
    logic              i_s_tlast = 1'b0;
    logic              i_m_tready = 1'b0;
    logic              o_s_tready, o_m_tvalid, o_m_tuser, o_m_tlast;
    logic [63:0]       o_m_tdata;

    terrain_visible_length_sweep_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [23:0]      height;
    longint           pv_x, pv_y, bk_x, bk_y;
    bit               pv_ok, bk_ok;
    logic [TOT_W-1:0] sum_len;

    t_edge_res expected_edges[$];
    int        n_fail, n_results, n_partial, n_polylines;
    bit        stall_heavy;

    function automatic longint root_floor(longint v);
        longint r, bt;
        r = 0;
        bt = 64'sd1 <<< 62;
        while (bt > v) bt = bt >>> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >>> 1) + bt;
            end else begin
                r = r >>> 1;
            end
            bt = bt >>> 2;
        end
        return r;
    endfunction

    function automatic t_edge_res predict_edge(logic [23:0] vx, logic [23:0] vy, logic lst);
        longint x, y, h, dx, dy, ln, a, b, n, d;
        longint unsigned ud, uq, vis;
        t_edge_res r;
        x = vx; y = vy; h = height; vis = 0;
        r.present = pv_ok;
        if (pv_ok && x > pv_x) begin
            dx = x - pv_x;
            dy = (y >= pv_y) ? y - pv_y : pv_y - y;
            ln = root_floor(dx * dx + dy * dy);
            if (pv_x == 0 && !bk_ok) begin
                vis = ln;
            end else if (pv_x * (y - h) - (pv_y - h) * x > 0) begin
                if (!bk_ok) begin
                    vis = ln;
                end else begin
                    b = bk_x;
                    a = bk_y - h;
                    if ((y - h) * b < a * x) begin
                        vis = 0;
                    end else if ((pv_y - h) * b >= a * pv_x) begin
                        vis = ln;
                    end else begin
                        n_partial++;
                        n = (h - pv_y) * b + a * pv_x;
                        d = (y - pv_y) * b - a * (x - pv_x);
                        if (d > 0) begin
                            if (n < 0) n = 0;
                            if (n > d) n = d;
                            ud = d;
                            uq = d - n;
                            while (ud >= 64'd4294967296) begin
                                ud = ud >> 1;
                                uq = uq >> 1;
                            end
                            vis = (ln * uq) / ud;
                        end
                    end
                end
            end
        end
        if (x > 0 && (!bk_ok || (y - h) * bk_x > (bk_y - h) * x)) begin
            bk_x = x; bk_y = y; bk_ok = 1;
        end
        pv_x = x; pv_y = y; pv_ok = 1;
        vis = vis & ((64'd1 << LEN_W) - 1);
        sum_len = (TOTAL_MAX - sum_len < vis) ? TOTAL_MAX : TOT_W'(sum_len + vis);
        r.vis_len = vis[LEN_W-1:0];
        r.total = sum_len;
        r.done = lst;
        if (lst) begin
            pv_x = 0; pv_y = 0; bk_x = 0; bk_y = 0; pv_ok = 0; bk_ok = 0; sum_len = '0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                t_edge_res e;
                n_results++;
                if (expected_edges.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_fail++;
                end else begin
                    e = expected_edges.pop_front();
                    if (o_m_tuser !== e.present) begin
                        $error("edge_present exp %0d got %0d", e.present, o_m_tuser);
                        n_fail++;
                    end
                    if (o_m_tdata[24:0] !== e.vis_len) begin
                        $error("edge_visible_length exp %0d got %0d", e.vis_len,
                               o_m_tdata[24:0]);
                        n_fail++;
                    end
                    if (o_m_tdata[60:25] !== e.total) begin
                        $error("total_visible exp %0d got %0d", e.total, o_m_tdata[60:25]);
                        n_fail++;
                    end
                    if (o_m_tlast !== e.done) begin
                        $error("polyline_done exp %0d got %0d", e.done, o_m_tlast);
                        n_fail++;
                    end
                end
            end
            if (stall_heavy) i_m_tready <= ($urandom_range(0, 7) == 0);
            else i_m_tready <= ($urandom_range(0, 4) != 0);
        end
    end

    // tvalid stays up after a beat until the next gap or drain takes it down
    task automatic send_vertex(logic [23:0] vx, logic [23:0] vy, logic lst,
                               bit known, t_edge_res want);
        t_edge_res p;
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {vy, vx};
        i_s_tlast <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        p = predict_edge(vx, vy, lst);
        if (known && p !== want) begin
            $error("table row disagrees with predictor at x=%0d y=%0d", vx, vy);
            n_fail++;
        end
        expected_edges.push_back(known ? want : p);
        if (lst) n_polylines++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_height(logic [23:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        height = v;
    endtask

    // one well-formed polyline with random content
    task automatic send_polyline(int nv, int step_max, bit noisy);
        logic [23:0] x, y;
        int j;
        x = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(0, 4000));
        y = 24'($urandom);
        for (j = 0; j < nv; j++) begin
            if (noisy && $urandom_range(0, 9) == 0) x = 24'($urandom);
            send_vertex(x, y, j == nv - 1, 0, '0);
            x = (32'(x) + 32'($urandom_range(1, step_max)) > 32'hFFFFFF) ? 24'hFFFFFF
                : x + 24'($urandom_range(1, step_max));
            case ($urandom_range(0, 3))
                0: y = 24'($urandom);
                1: y = y + 24'($urandom_range(0, 5000));
                2: y = y - 24'($urandom_range(0, 5000));
                default: y = y + 24'($urandom_range(0, 200000));
            endcase
        end
    endtask

    t_row dir_rows[$];
    int   total_sent;

    function automatic t_row mk(logic [23:0] x, logic [23:0] y, logic l, bit k,
                                t_edge_res r);
        t_row t;
        t.x = x; t.y = y; t.last = l; t.known = k; t.res = r;
        return t;
    endfunction

    initial begin
        n_fail = 0; n_results = 0; n_partial = 0; n_polylines = 0; total_sent = 0;
        stall_heavy = 0;
        height = '0; pv_x = 0; pv_y = 0; bk_x = 0; bk_y = 0; pv_ok = 0; bk_ok = 0;
        sum_len = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first vertex, full rise from x=0, falling edge, collinear, non-increasing x,
        // extremes of the fields
        dir_rows.push_back(mk(24'd0, 24'd0, 0, 1, '{0, 0, 0, 0}));
        dir_rows.push_back(mk(24'd768, 24'd1024, 0, 1, '{1, 1280, 1280, 0}));
        dir_rows.push_back(mk(24'd1024, 24'd512, 0, 1, '{1, 0, 1280, 0}));
        dir_rows.push_back(mk(24'd2048, 24'd1024, 0, 0, '0));
        dir_rows.push_back(mk(24'd2048, 24'd9000, 0, 1, '{1, 0, 1280, 0}));
        dir_rows.push_back(mk(24'd1000, 24'd20000, 0, 1, '{1, 0, 1280, 0}));
        dir_rows.push_back(mk(24'd3000, 24'd30000, 0, 0, '0));
        dir_rows.push_back(mk(24'd4000, 24'd30000, 1, 0, '0));
        dir_rows.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 1, 1, '{0, 0, 0, 1}));
        dir_rows.push_back(mk(24'd0, 24'hFFFFFF, 0, 1, '{0, 0, 0, 0}));
        dir_rows.push_back(mk(24'hFFFFFF, 24'd0, 1, 0, '0));
        dir_rows.push_back(mk(24'd0, 24'd0, 0, 1, '{0, 0, 0, 0}));
        dir_rows.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 1, 0, '0));
        // blocker, then an edge that climbs past its sightline (partial case)
        dir_rows.push_back(mk(24'd256, 24'd2560, 0, 0, '0));
        dir_rows.push_back(mk(24'd512, 24'd256, 0, 0, '0));
        dir_rows.push_back(mk(24'd2560, 24'd40000, 0, 0, '0));
        dir_rows.push_back(mk(24'd3000, 24'd800, 0, 0, '0));
        dir_rows.push_back(mk(24'd3200, 24'd100, 1, 0, '0));
        foreach (dir_rows[i]) begin
            send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                        dir_rows[i].known, dir_rows[i].res);
            total_sent++;
        end

        // hold off until everything is back, then the observer heights
        set_height(24'hFFFFFF);
        send_polyline(6, 3000, 0);
        set_height(24'd2560);
        send_polyline(6, 3000, 0);
        total_sent += 12;
        set_height(24'd0);

        while (total_sent < 1650) begin
            int nv;
            if ($urandom_range(0, 40) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_height(24'd0);
                    1: set_height(24'hFFFFFF);
                    default: set_height(24'($urandom));
                endcase
            end
            stall_heavy = ($urandom_range(0, 9) == 0);
            nv = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 60)
                 : $urandom_range(2, 10);
            if ($urandom_range(0, 5) == 0) begin
                repeat (nv) begin
                    send_vertex(24'($urandom), 24'($urandom), $urandom_range(0, 5) == 0,
                                0, '0);
                end
            end else begin
                send_polyline(nv, ($urandom_range(0, 4) == 0) ? 2000000 : 4000,
                              $urandom_range(0, 5) == 0);
            end
            total_sent += nv;
        end
        stall_heavy = 0;
        drain();

        $display("covered %0d vertices in %0d polylines, %0d results, %0d partly visible edges",
                 total_sent, n_polylines, n_results, n_partial);
        $display("observer height swept across zero, full scale and random values");
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end
endmodule
